// ----- src/salwc_pkg.sv -----
package salwc_pkg;

	localparam int ADDR_W    = 32;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int LRU_W     = 3;
	localparam int SET_MAX_W = 16;
	localparam int SH_W      = 5;
	localparam int WAYS_W    = 5;
	localparam int OFF_MAX   = 12;
	localparam int IDX_MAX   = 10;

	localparam logic [LRU_W-1:0] LRU_MAX = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

	// one way of a set row
	typedef struct packed {
		logic [ADDR_W-1:0] tag;
		logic              valid;
		logic              dirty;
		logic [LRU_W-1:0]  lru;
	} way_t;

	// classified access, front to back
	typedef struct packed {
		logic                 func;
		logic [ADDR_W-1:0]    address;
		logic [ADDR_W-1:0]    tag;
		logic [SET_MAX_W-1:0] set;
		logic [CFG_W-1:0]     off;
		logic [SH_W-1:0]      sh;
		logic [WAYS_W-1:0]    nways;
	} entry_t;

endpackage

// ----- src/salwc_req_if.sv -----
interface salwc_req_if import salwc_pkg::*;;
	logic              valid;
	logic              ready;
	logic              func;
	logic [ADDR_W-1:0] address;

	modport source (output valid, func, address, input ready);
	modport sink (input valid, func, address, output ready);
endinterface

// ----- src/salwc_rsp_if.sv -----
interface salwc_rsp_if import salwc_pkg::*;;
	logic              valid;
	logic              ready;
	logic              hit;
	logic              writeback_valid;
	logic [ADDR_W-1:0] writeback_address;
	logic              fetch_valid;
	logic [ADDR_W-1:0] fetch_address;

	modport source (output valid, hit, writeback_valid, writeback_address, fetch_valid,
		fetch_address, input ready);
	modport sink (input valid, hit, writeback_valid, writeback_address, fetch_valid,
		fetch_address, output ready);
endinterface

// ----- src/salwc_ram.sv -----
module salwc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/salwc_front.sv -----
module salwc_front import salwc_pkg::*; #(
	parameter int MAX_SETS = 1024,
	parameter int MAX_WAYS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	salwc_req_if.sink            req,
	input  logic                 hold,
	output logic                 q_valid,
	input  logic                 q_pop,
	output entry_t               q_head
);

	localparam int LIM     = $clog2(MAX_SETS + 1) - 1;
	localparam int IDX_LIM = (LIM < IDX_MAX) ? LIM : IDX_MAX;

	logic [CFG_W-1:0] off_q, idx_q, ways_q;
	logic [CFG_W-1:0] off, idx;
	logic [WAYS_W-1:0] nways;
	logic [ADDR_W-1:0] set32;
	entry_t ent;
	entry_t q_mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= 4'd5;
			idx_q  <= 4'd5;
			ways_q <= 4'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OFFSET_BITS: off_q  <= cfg_data;
				REG_INDEX_BITS:  idx_q  <= cfg_data;
				REG_WAYS_IN_USE: ways_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp configuration into range
	always_comb begin
		off = (off_q > CFG_W'(OFF_MAX)) ? CFG_W'(OFF_MAX) : off_q;
		idx = (idx_q > CFG_W'(IDX_LIM)) ? CFG_W'(IDX_LIM) : idx_q;
		if (ways_q == '0) begin
			nways = WAYS_W'(1);
		end else if ({1'b0, ways_q} > WAYS_W'(MAX_WAYS)) begin
			nways = WAYS_W'(MAX_WAYS);
		end else begin
			nways = {1'b0, ways_q};
		end
		set32       = (req.address >> off) & ((32'd1 << idx) - 32'd1);
		ent.func    = req.func;
		ent.address = req.address;
		ent.off     = off;
		ent.sh      = SH_W'(off) + SH_W'(idx);
		ent.tag     = req.address >> ent.sh;
		ent.set     = set32[SET_MAX_W-1:0];
		ent.nways   = nways;
	end

	assign req.ready = !hold && (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_head    = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wp_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// ----- src/salwc_back.sv -----
module salwc_back import salwc_pkg::*; #(
	parameter int MAX_SETS = 1024,
	parameter int MAX_WAYS = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_valid,
	output logic  q_pop,
	input  entry_t q_head,
	output logic  clearing,
	salwc_rsp_if.source rsp
);

	localparam int LIM   = $clog2(MAX_SETS + 1) - 1;
	localparam int SET_W = (LIM > 0) ? LIM : 1;
	localparam int DEPTH = 2 ** LIM;
	localparam int WAY_W = $bits(way_t);
	localparam int ROW_W = WAY_W * MAX_WAYS;
	localparam int WI_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

	localparam logic [1:0] ST_CLR = 2'd0;
	localparam logic [1:0] ST_RD  = 2'd1;
	localparam logic [1:0] ST_UPD = 2'd2;

	logic [1:0] state_q;
	logic [SET_W-1:0] clr_q;
	entry_t ent_s1;
	logic ov_q, hit_q, wbv_q, fv_q;
	logic [ADDR_W-1:0] wba_q, fa_q;

	logic we;
	logic [SET_W-1:0] waddr;
	logic [ROW_W-1:0] wdata, rdata;
	way_t [MAX_WAYS-1:0] row, nrow;
	logic out_free;

	logic hit, found_free, bump;
	logic [WI_W-1:0] hw, fw, vm, sel;
	logic [LRU_W-1:0] old;
	logic wbv;
	logic [ADDR_W-1:0] wba;

	salwc_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (q_head.set[SET_W-1:0]),
		.rdata (rdata)
	);

	assign row      = rdata;
	assign clearing = (state_q == ST_CLR);
	assign out_free = !ov_q || rsp.ready;
	assign q_pop    = (state_q == ST_RD) && q_valid && out_free;

	// hit search, free way, largest lru count
	always_comb begin
		hit = 1'b0;
		hw = '0;
		found_free = 1'b0;
		fw = '0;
		vm = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (WAYS_W'(w) < ent_s1.nways) begin
				if (!hit && row[w].valid && row[w].tag == ent_s1.tag) begin
					hit = 1'b1;
					hw = WI_W'(w);
				end
				if (!found_free && !row[w].valid) begin
					found_free = 1'b1;
					fw = WI_W'(w);
				end
				if (row[w].lru > row[vm].lru) begin
					vm = WI_W'(w);
				end
			end
		end
		sel = hit ? hw : (found_free ? fw : vm);
		old = row[sel].lru;

		for (int w = 0; w < MAX_WAYS; w++) begin
			nrow[w] = row[w];
			bump = 1'b0;
			if (WAYS_W'(w) < ent_s1.nways && WI_W'(w) != sel) begin
				if (!hit && found_free) begin
					bump = row[w].valid;
				end else begin
					bump = (row[w].lru < old);
				end
			end
			if (bump && row[w].lru != LRU_MAX) begin
				nrow[w].lru = row[w].lru + 3'd1;
			end
		end
		nrow[sel].lru = '0;
		if (hit) begin
			nrow[sel].dirty = row[sel].dirty | ent_s1.func;
		end else begin
			nrow[sel].tag   = ent_s1.tag;
			nrow[sel].valid = 1'b1;
			nrow[sel].dirty = ent_s1.func;
		end

		wbv = !hit && !found_free && row[vm].dirty;
		wba = wbv ? ((row[vm].tag << ent_s1.sh) |
			(ADDR_W'(ent_s1.set) << ent_s1.off)) : '0;
	end

	always_comb begin
		we    = 1'b0;
		waddr = ent_s1.set[SET_W-1:0];
		wdata = nrow;
		if (state_q == ST_CLR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (state_q == ST_UPD) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_s1 <= q_head;
		end
		if (state_q == ST_UPD) begin
			hit_q <= hit;
			wbv_q <= wbv;
			wba_q <= wba;
			fv_q  <= !hit;
			fa_q  <= hit ? '0 : ent_s1.address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (rsp.ready) ov_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SET_W'(DEPTH - 1)) state_q <= ST_RD;
				end
				ST_RD: begin
					if (q_pop) state_q <= ST_UPD;
				end
				ST_UPD: begin
					ov_q    <= 1'b1;
					state_q <= ST_RD;
				end
				default: state_q <= ST_RD;
			endcase
		end
	end

	assign rsp.valid             = ov_q;
	assign rsp.hit               = hit_q;
	assign rsp.writeback_valid   = wbv_q;
	assign rsp.writeback_address = wba_q;
	assign rsp.fetch_valid       = fv_q;
	assign rsp.fetch_address     = fa_q;

endmodule

// ----- src/set_assoc_lru_writeback_cache.sv -----
// channel  dir  beat payload                                          handshake
// req      in   func, address                                         valid/ready
// rsp      out  hit, writeback_valid/address, fetch_valid/address     valid/ready
// cfg      in   cfg_index, cfg_data                                   cfg_we, no wait
//
// each access is a set-row read of the tag ram from the registered-read row
// memory (ST_RD), then compare, lru update and row write (ST_UPD)
// after reset the tag ram is swept, one row per cycle, over all
// 2**floor(log2 MAX_SETS) rows (1024 by default); req is held off meanwhile
// a two-beat queue parts the front (classify) from the back (tag ram update);
// the back starts a new access only once the result register is free or
// its beat leaves in the same cycle, so a stalled rsp stalls the back
module set_assoc_lru_writeback_cache import salwc_pkg::*; #(
	parameter int MAX_SETS = 1024,
	parameter int MAX_WAYS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	salwc_req_if.sink            req,
	salwc_rsp_if.source          rsp
);

	// queue head between front and back
	logic   q_valid;
	logic   q_pop;
	entry_t q_head;
	// back is sweeping the store after reset
	logic   clearing;

	// config registers, range clamp, set/tag split and the queue
	salwc_front #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.hold      (clearing),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_head    (q_head)
	);

	// tag ram, hit/victim select, lru and dirty update, result register
	salwc_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_head   (q_head),
		.clearing (clearing),
		.rsp      (rsp)
	);

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
	import salwc_pkg::*;

	localparam int NSETS = 1024;
	localparam int NWAYS = 8;
	localparam int LIMIT = 400000;

	// one access as sent on the request channel
	typedef struct packed {
		logic              func;
		logic [ADDR_W-1:0] address;
	} access_t;

	// one response beat as predicted
	typedef struct packed {
		logic              hit;
		logic              wb_valid;
		logic [ADDR_W-1:0] wb_addr;
		logic              fetch_valid;
		logic [ADDR_W-1:0] fetch_addr;
	} outcome_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	salwc_req_if req_ch();
	salwc_rsp_if rsp_ch();

	set_assoc_lru_writeback_cache u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch.sink),
		.rsp       (rsp_ch.source)
	);

	// shadow of the tag/state store
	logic [ADDR_W-1:0] shadow_tag   [NSETS*NWAYS];
	logic              shadow_valid [NSETS*NWAYS];
	logic              shadow_dirty [NSETS*NWAYS];
	logic [LRU_W-1:0]  shadow_lru   [NSETS*NWAYS];
	logic [CFG_W-1:0]  cur_off, cur_idx, cur_ways;

	access_t  pending_accesses[$];
	outcome_t expected_outcomes[$];
	int       errors;
	int       cycle;
	bit       hold_off;
	bit       stim_done;
	int       burst_left, gap_left;

	always #6 clk = ~clk;

	// predict one access and update the shadow store
	function automatic outcome_t predict_access(access_t a);
		outcome_t o;
		int off, idx, nw, base, hw, vw;
		logic [ADDR_W-1:0] set_no, tg;
		logic [LRU_W-1:0] old;
		bit hit_f, free_f;
		o = '0;
		off = (cur_off > OFF_MAX) ? OFF_MAX : cur_off;
		idx = (cur_idx > IDX_MAX) ? IDX_MAX : cur_idx;
		nw = (cur_ways < 1) ? 1 : ((cur_ways > NWAYS) ? NWAYS : cur_ways);
		set_no = (a.address >> off) & ((32'd1 << idx) - 1);
		tg = a.address >> (off + idx);
		base = set_no * NWAYS;
		hit_f = 0; hw = 0;
		for (int w = 0; w < nw; w++)
			if (!hit_f && shadow_valid[base+w] && shadow_tag[base+w] == tg) begin
				hit_f = 1;
				hw = w;
			end
		if (hit_f) begin
			old = shadow_lru[base+hw];
			for (int w = 0; w < nw; w++)
				if (w != hw && shadow_lru[base+w] < old && shadow_lru[base+w] < LRU_MAX)
					shadow_lru[base+w]++;
			shadow_lru[base+hw] = '0;
			if (a.func) shadow_dirty[base+hw] = 1;
		end else begin
			free_f = 0; vw = 0;
			for (int w = 0; w < nw; w++)
				if (!free_f && !shadow_valid[base+w]) begin
					free_f = 1;
					vw = w;
				end
			if (free_f) begin
				for (int w = 0; w < nw; w++)
					if (w != vw && shadow_valid[base+w] && shadow_lru[base+w] < LRU_MAX)
						shadow_lru[base+w]++;
			end else begin
				// first way with the largest count is the victim
				for (int w = 1; w < nw; w++)
					if (shadow_lru[base+w] > shadow_lru[base+vw]) vw = w;
				old = shadow_lru[base+vw];
				if (shadow_dirty[base+vw]) begin
					o.wb_valid = 1;
					o.wb_addr = (shadow_tag[base+vw] << (off + idx)) | (set_no << off);
				end
				for (int w = 0; w < nw; w++)
					if (w != vw && shadow_lru[base+w] < old && shadow_lru[base+w] < LRU_MAX)
						shadow_lru[base+w]++;
			end
			shadow_tag[base+vw] = tg;
			shadow_valid[base+vw] = 1;
			shadow_dirty[base+vw] = a.func;
			shadow_lru[base+vw] = '0;
			o.fetch_valid = 1;
			o.fetch_addr = a.address;
		end
		o.hit = hit_f;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
		input logic [ADDR_W-1:0] want);
		$display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle);
		errors++;
	endtask

	// write one register while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] r, input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		case (r)
			REG_OFFSET_BITS: cur_off = v;
			REG_INDEX_BITS:  cur_idx = v;
			default:         cur_ways = v;
		endcase
	endtask

	// sample after the edge has settled so a beat just launched is seen
	task automatic wait_drained;
		while (pending_accesses.size() != 0 || req_ch.valid || expected_outcomes.size() != 0)
		begin
			@(posedge clk);
			#1;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic queue_access(input logic f, input logic [ADDR_W-1:0] ad);
		access_t a;
		a.func = f;
		a.address = ad;
		pending_accesses.push_back(a);
	endtask

	// random accesses over a small pool of tags so that hits, evictions and write-backs occur
	task automatic random_phase(input int n);
		logic [ADDR_W-1:0] ad;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0:       ad = $urandom();
				1:       ad = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 255) :
					$urandom_range(0, 255);
				default: ad = ($urandom_range(0, 15) << 14) | ($urandom_range(0, 3) << 8) |
					$urandom_range(0, 255) | ($urandom_range(0, 1) << 31);
			endcase
			queue_access($urandom_range(0, 1), ad);
		end
	endtask

	// request driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 0;
			req_ch.func <= 0;
			req_ch.address <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (!req_ch.valid || req_ch.ready) begin
				if (req_ch.valid) expected_outcomes.push_back(predict_access(
					{req_ch.func, req_ch.address}));
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req_ch.valid <= 0;
				end else if (pending_accesses.size() != 0 && !hold_off) begin
					access_t a;
					a = pending_accesses.pop_front();
					req_ch.valid <= 1;
					req_ch.func <= a.func;
					req_ch.address <= a.address;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 20);
						gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_ch.valid <= 0;
				end
			end
		end
	end

	// response monitor with its own stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_outcomes.size() == 0) begin
					$display("unexpected response beat (cycle %0d)", cycle);
					errors++;
				end else begin
					outcome_t e;
					e = expected_outcomes.pop_front();
					if (rsp_ch.hit !== e.hit) report_mismatch("hit", rsp_ch.hit, e.hit);
					if (rsp_ch.writeback_valid !== e.wb_valid)
						report_mismatch("writeback_valid", rsp_ch.writeback_valid, e.wb_valid);
					if (rsp_ch.writeback_address !== e.wb_addr)
						report_mismatch("writeback_address", rsp_ch.writeback_address, e.wb_addr);
					if (rsp_ch.fetch_valid !== e.fetch_valid)
						report_mismatch("fetch_valid", rsp_ch.fetch_valid, e.fetch_valid);
					if (rsp_ch.fetch_address !== e.fetch_addr)
						report_mismatch("fetch_address", rsp_ch.fetch_address, e.fetch_addr);
				end
			end
			// stall pattern: long ready stretches while cycle[7:6] is zero, random stalls otherwise
			rsp_ch.ready <= (cycle[7:6] == 2'b00) ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		clk = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_OFFSET_BITS;
		cfg_data = '0;
		errors = 0;
		cycle = 0;
		hold_off = 0;
		stim_done = 0;
		cur_off = 5;
		cur_idx = 5;
		cur_ways = 4;
		for (int i = 0; i < NSETS*NWAYS; i++) begin
			shadow_tag[i] = '0;
			shadow_valid[i] = 0;
			shadow_dirty[i] = 0;
			shadow_lru[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// directed: fill one set of reset geometry, hit, evict dirty and clean
		for (int t = 0; t < 5; t++) queue_access(t[0], t << 10);
		queue_access(0, 32'h0000_0000);
		queue_access(1, 32'h0000_0C1F);
		queue_access(0, 32'hFFFF_FFFF);
		queue_access(1, 32'hFFFF_FFE0);
		queue_access(0, 32'h8000_0000);
		for (int t = 5; t < 9; t++) queue_access(1, t << 10);
		wait_drained();

		// second phase: hold_off is raised while the accesses are queued and dropped before draining
		hold_off = 1;
		random_phase(60);
		hold_off = 0;
		wait_drained();

		// one way, no index bits, zero offset: single-block cache
		write_reg(REG_OFFSET_BITS, 4'd0);
		write_reg(REG_INDEX_BITS, 4'd0);
		write_reg(REG_WAYS_IN_USE, 4'd1);
		queue_access(1, 32'h1234_5678);
		queue_access(0, 32'h1234_5678);
		queue_access(0, 32'h1234_5679);
		queue_access(0, 32'hFFFF_FFFF);
		random_phase(60);
		wait_drained();

		// out-of-range values saturate
		write_reg(REG_OFFSET_BITS, 4'd15);
		write_reg(REG_INDEX_BITS, 4'd15);
		write_reg(REG_WAYS_IN_USE, 4'd0);
		random_phase(60);
		wait_drained();

		// largest legal values with 8 ways, then wider than max ways
		write_reg(REG_OFFSET_BITS, 4'd12);
		write_reg(REG_INDEX_BITS, 4'd10);
		write_reg(REG_WAYS_IN_USE, 4'd8);
		random_phase(100);
		wait_drained();
		write_reg(REG_OFFSET_BITS, 4'd2);
		write_reg(REG_INDEX_BITS, 4'd2);
		write_reg(REG_WAYS_IN_USE, 4'd15);
		random_phase(120);
		wait_drained();

		// shrink ways so stale lru counts saturate, then back to reset geometry
		write_reg(REG_WAYS_IN_USE, 4'd3);
		random_phase(100);
		wait_drained();
		write_reg(REG_OFFSET_BITS, 4'd5);
		write_reg(REG_INDEX_BITS, 4'd5);
		write_reg(REG_WAYS_IN_USE, 4'd4);
		random_phase(130);
		wait_drained();
		repeat (20) @(posedge clk);

		if (errors == 0 && expected_outcomes.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
